/* design/rswd_pkg.sv */
// Package for the readout spill word decoder: record codes, word markers,
// phase encoding and the command that travels from front to back.
// No dependencies.
package rswd_pkg;

  localparam logic [31:0] NibMask     = 32'hf000_0000;
  localparam logic [31:0] NibHeader   = 32'h7000_0000;
  localparam logic [31:0] NibTrailer  = 32'hf000_0000;
  localparam logic [31:0] WordKilled  = 32'h666c_affe;
  localparam logic [31:0] WordRoll    = 32'h5c5c_5c5c;
  localparam logic [24:0] RollMax     = 25'h1ff_ffff;

  // command queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    RecHit     = 2'd0,
    RecHeader  = 2'd1,
    RecTrailer = 2'd2,
    RecKilled  = 2'd3
  } rec_type_e;

  typedef enum logic [3:0] {
    PhHunt  = 4'b0001,
    PhSpill = 4'b0010,
    PhHdr2  = 4'b0100,
    PhTrl2  = 4'b1000
  } phase_e;

  // one classified word, ready for unpacking
  typedef struct packed {
    rec_type_e    kind;
    logic [4:0]   fifo;
    logic [31:0]  word;
    logic [11:0]  counter;
    logic [7:0]   time_high;
    logic [24:0]  roll;
  } cmd_t;

  // one decoded result
  typedef struct packed {
    rec_type_e    record_type;
    logic [4:0]   source_fifo;
    logic [11:0]  spill_counter;
    logic [2:0]   column;
    logic [2:0]   pixel;
    logic [1:0]   tdc;
    logic [24:0]  rollover;
    logic [14:0]  coarse;
    logic [8:0]   fine;
  } rec_t;

endpackage

/* design/rswd_front.sv */
// Front of the spill word decoder: phase tracking, rollover counting and
// classification of accepted words into commands. Uses rswd_pkg.
module rswd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [31:0]   data_word_i,
  input  logic [4:0]    fifo_id_i,
  output logic          q_push_o,
  output rswd_pkg::cmd_t cmd_o
);
  import rswd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [11:0] held_counter_q, held_counter_d;
  logic [7:0]  held_high_q, held_high_d;
  logic [24:0] roll_q, roll_d;
  logic        is_header, is_trailer;

  assign is_header  = (data_word_i & NibMask) == NibHeader;
  assign is_trailer = (data_word_i & NibMask) == NibTrailer;

  always_comb begin
    phase_d        = phase_q;
    held_counter_d = held_counter_q;
    held_high_d    = held_high_q;
    roll_d         = roll_q;
    q_push_o       = 1'b0;
    cmd_o.kind      = RecHit;
    cmd_o.fifo      = fifo_id_i;
    cmd_o.word      = data_word_i;
    cmd_o.counter   = held_counter_q;
    cmd_o.time_high = held_high_q;
    cmd_o.roll      = roll_q;
    if (valid_i) begin
      unique case (phase_q)
        PhHunt: begin
          if (is_header) begin
            held_counter_d = data_word_i[27:16];
            held_high_d    = data_word_i[7:0];
            phase_d        = PhHdr2;
          end
        end
        PhHdr2: begin
          // second word is the low time whatever it looks like
          q_push_o   = 1'b1;
          cmd_o.kind = RecHeader;
          phase_d    = PhSpill;
        end
        PhTrl2: begin
          q_push_o   = 1'b1;
          cmd_o.kind = RecTrailer;
          phase_d    = PhHunt;
          roll_d     = '0;
        end
        PhSpill: begin
          if (data_word_i == WordKilled) begin
            q_push_o   = 1'b1;
            cmd_o.kind = RecKilled;
            phase_d    = PhHunt;
            roll_d     = '0;
          end else if (is_trailer) begin
            held_counter_d = data_word_i[27:16];
            held_high_d    = data_word_i[7:0];
            phase_d        = PhTrl2;
          end else if (data_word_i == WordRoll) begin
            // saturate at full scale
            if (roll_q != RollMax) roll_d = roll_q + 25'd1;
          end else begin
            q_push_o   = 1'b1;
            cmd_o.kind = RecHit;
          end
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhHunt;
      held_counter_q <= '0;
      held_high_q    <= '0;
      roll_q         <= '0;
    end else begin
      phase_q        <= phase_d;
      held_counter_q <= held_counter_d;
      held_high_q    <= held_high_d;
      roll_q         <= roll_d;
    end
  end

`ifndef SYNTH
  // the rollover count is cleared whenever a spill is left
  a_hunt_roll_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhHunt) |-> (roll_q == '0))
    else $error("rollover count nonzero while hunting");

  a_hunt_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && phase_q == PhHunt) |-> !q_push_o)
    else $error("record emitted outside a spill");

  a_killed_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && phase_q == PhSpill && data_word_i == WordKilled) |=>
      (phase_q == PhHunt))
    else $error("killed word did not leave the spill");

  a_second_word_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && (phase_q == PhHdr2 || phase_q == PhTrl2)) |-> q_push_o)
    else $error("second header or trailer word gave no record");
`endif

endmodule

/* design/rswd_queue.sv */
// Short command queue that decouples the decoder front from the back.
// Uses rswd_pkg for depth and the command type.
module rswd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rswd_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output rswd_pkg::cmd_t data_o
);
  import rswd_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == QCntW'(QDepth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q == rd_ptr_q) |-> (empty_o || full_o))
    else $error("queue pointers disagree with count");
`endif

endmodule

/* design/rswd_back.sv */
// Back of the spill word decoder: unpacks queued commands into records and
// holds the oldest one in an output register. Uses rswd_pkg.
module rswd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  rswd_pkg::cmd_t cmd_i,
  output logic           q_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output rswd_pkg::rec_t rec_o
);
  import rswd_pkg::*;

  logic        valid_q;
  rec_t        rec_q, rec_d;
  logic [39:0] full_time;

  assign full_time = {cmd_i.time_high, cmd_i.word};
  // refill the output register when it is empty or being drained
  assign q_pop_o   = !q_empty_i && (!valid_q || pop_i);

  always_comb begin
    rec_d             = '0;
    rec_d.record_type = cmd_i.kind;
    rec_d.source_fifo = cmd_i.fifo;
    unique case (cmd_i.kind)
      RecHit: begin
        rec_d.column   = cmd_i.word[31:29];
        rec_d.pixel    = cmd_i.word[28:26];
        rec_d.tdc      = cmd_i.word[25:24];
        rec_d.rollover = cmd_i.roll;
        rec_d.coarse   = cmd_i.word[23:9];
        rec_d.fine     = cmd_i.word[8:0];
      end
      RecHeader, RecTrailer: begin
        rec_d.spill_counter = cmd_i.counter;
        rec_d.rollover      = full_time[39:15];
        rec_d.coarse        = full_time[14:0];
      end
      RecKilled: begin
        rec_d.rollover = '0;
      end
      default: begin
        rec_d.rollover = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) rec_q <= rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  assign empty_o = !valid_q;
  assign rec_o   = rec_q;

`ifndef SYNTH
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !pop_i) |=> (valid_q && rec_q == $past(rec_q)))
    else $error("stalled record changed");

  a_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_empty_i && !valid_q) |-> q_pop_o)
    else $error("output register idle with queued commands");

  a_killed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && rec_q.record_type == RecKilled) |->
      (rec_q.rollover == '0 && rec_q.coarse == '0 && rec_q.spill_counter == '0))
    else $error("killed record carries payload");
`endif

endmodule

/* design/readout_spill_word_decoder.sv */
// Readout spill word decoder: takes one 32-bit readout word and its FIFO id
// per cycle and emits at most one decoded record (hit, spill header, spill
// trailer or killed FIFO) per word. Sustained rate is one word per clock while
// full is low; each record waits in the command queue, then in the output
// register. A four-entry command queue and one output register sit between
// the classifier and the result ports, so full rises only once four records
// are waiting behind an unpopped output. Words outside a spill that are not
// headers are dropped without a record. Uses rswd_pkg.
module readout_spill_word_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] data_word_i,
  input  logic [4:0]  fifo_id_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  record_type_o,
  output logic [4:0]  source_fifo_o,
  output logic [11:0] spill_counter_o,
  output logic [2:0]  column_o,
  output logic [2:0]  pixel_o,
  output logic [1:0]  tdc_o,
  output logic [24:0] rollover_o,
  output logic [14:0] coarse_o,
  output logic [8:0]  fine_o
);
  import rswd_pkg::*;

  logic accept;
  logic f_push;
  cmd_t f_cmd, q_cmd;
  logic q_full, q_empty, q_pop;
  rec_t rec;

  assign full   = q_full;
  assign accept = push && !q_full;

  rswd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .data_word_i (data_word_i),
    .fifo_id_i   (fifo_id_i),
    .q_push_o    (f_push),
    .cmd_o       (f_cmd)
  );

  rswd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_cmd)
  );

  rswd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .cmd_i     (q_cmd),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .rec_o     (rec)
  );

  assign record_type_o   = rec.record_type;
  assign source_fifo_o   = rec.source_fifo;
  assign spill_counter_o = rec.spill_counter;
  assign column_o        = rec.column;
  assign pixel_o         = rec.pixel;
  assign tdc_o           = rec.tdc;
  assign rollover_o      = rec.rollover;
  assign coarse_o        = rec.coarse;
  assign fine_o          = rec.fine;

endmodule

/* tb/sv/tb_top.sv */
// Testbench for readout_spill_word_decoder: directed, spill-shaped random and
// noise word streams, with every record checked against an in-bench decoder.
// Depends on rswd_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import rswd_pkg::*;

  localparam int unsigned SpillItems  = 1500;
  localparam int unsigned NoiseItems  = 200;
  localparam int unsigned IdleLimit   = 500;
  localparam int unsigned SettleTicks = 16;
  localparam int unsigned MaxPrinted  = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] data_word_i = '0;
  logic [4:0]  fifo_id_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  record_type_o;
  logic [4:0]  source_fifo_o;
  logic [11:0] spill_counter_o;
  logic [2:0]  column_o;
  logic [2:0]  pixel_o;
  logic [1:0]  tdc_o;
  logic [24:0] rollover_o;
  logic [14:0] coarse_o;
  logic [8:0]  fine_o;

  // decoder state mirrored in the bench
  phase_e      spill_phase = PhHunt;
  logic [11:0] held_count = '0;
  logic [7:0]  held_high = '0;
  logic [24:0] roll_count = '0;

  rec_t        pending_records[$];
  int unsigned decoded_words = 0;
  int unsigned err_count = 0;
  bit          push_idle_en = 1'b0;
  bit          pop_idle_en = 1'b0;

  readout_spill_word_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .data_word_i     (data_word_i),
    .fifo_id_i       (fifo_id_i),
    .empty           (empty),
    .pop             (pop),
    .record_type_o   (record_type_o),
    .source_fifo_o   (source_fifo_o),
    .spill_counter_o (spill_counter_o),
    .column_o        (column_o),
    .pixel_o         (pixel_o),
    .tdc_o           (tdc_o),
    .rollover_o      (rollover_o),
    .coarse_o        (coarse_o),
    .fine_o          (fine_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    if (err_count <= MaxPrinted) begin
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    end
  endtask

  // Advance the decoder by one accepted word; queue the record it completes.
  function automatic void decode_word(logic [31:0] w, logic [4:0] f);
    rec_t        rec;
    logic [39:0] stamp;
    rec = '0;
    rec.source_fifo = f;
    decoded_words++;
    case (spill_phase)
      PhHunt: begin
        if ((w & NibMask) == NibHeader) begin
          held_count = w[27:16];
          held_high = w[7:0];
          spill_phase = PhHdr2;
        end
        return;
      end
      PhHdr2, PhTrl2: begin
        // second word is always time, whatever it looks like
        stamp = {held_high, w};
        rec.spill_counter = held_count;
        rec.rollover = stamp[39:15];
        rec.coarse = stamp[14:0];
        if (spill_phase == PhHdr2) begin
          rec.record_type = RecHeader;
          spill_phase = PhSpill;
        end else begin
          rec.record_type = RecTrailer;
          spill_phase = PhHunt;
          roll_count = '0;
        end
      end
      default: begin
        if (w == WordKilled) begin
          rec.record_type = RecKilled;
          spill_phase = PhHunt;
          roll_count = '0;
        end else if ((w & NibMask) == NibTrailer) begin
          held_count = w[27:16];
          held_high = w[7:0];
          spill_phase = PhTrl2;
          return;
        end else if (w == WordRoll) begin
          if (roll_count != RollMax) roll_count++;
          return;
        end else begin
          rec.record_type = RecHit;
          rec.column = w[31:29];
          rec.pixel = w[28:26];
          rec.tdc = w[25:24];
          rec.rollover = roll_count;
          rec.coarse = w[23:9];
          rec.fine = w[8:0];
        end
      end
    endcase
    pending_records.push_back(rec);
  endfunction

  // Called and returning just after a falling edge.
  task automatic send_word(logic [31:0] w, logic [4:0] f);
    int gap;
    gap = push_idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    data_word_i <= w;
    fifo_id_i <= f;
    do @(posedge clk_i); while (full);
    decode_word(w, f);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] draw_hit_word();
    logic [31:0] w;
    w = $urandom;
    while ((w & NibMask) == NibTrailer || w == WordKilled || w == WordRoll) w = $urandom;
    return w;
  endfunction

  // Low time word: mostly random, sometimes a value that looks like a marker.
  function automatic logic [31:0] draw_time_low();
    case ($urandom_range(0, 9))
      0: return WordKilled;
      1: return WordRoll;
      2: return NibHeader | ($urandom & ~NibMask);
      3: return NibTrailer | ($urandom & ~NibMask);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] draw_fifo();
    return 5'($urandom_range(0, 31));
  endfunction

  task automatic test_directed_cases();
    push_idle_en = 1'b0;
    pop_idle_en = 1'b1;
    // dropped while hunting
    send_word(32'h1234_5678, 5'd0);
    send_word(WordKilled, 5'd3);
    send_word(WordRoll, 5'd4);
    send_word(32'hf000_0000, 5'd5);
    // header with all-ones counter and time
    send_word(32'h7fff_00ff, 5'd31);
    send_word(32'hffff_ffff, 5'd23);
    send_word(32'hefff_ffff, 5'd31);
    send_word(32'h0000_0000, 5'd0);
    send_word(WordRoll, 5'd1);
    send_word(WordRoll, 5'd2);
    send_word(WordRoll, 5'd3);
    // header nibble inside a spill is a hit
    send_word(32'h7abc_def0, 5'd24);
    send_word(32'hf000_0000, 5'd5);
    send_word(WordKilled, 5'd24);
    // rollover count must be clear in the next spill
    send_word(32'h7000_0000, 5'd1);
    send_word(32'h7fff_ffff, 5'd2);
    send_word(32'h1234_5678, 5'd6);
    send_word(WordRoll, 5'd7);
    send_word(32'h1fff_fe00, 5'd8);
    send_word(WordKilled, 5'd30);
    send_word(32'h2000_0001, 5'd9);
    push_idle_en = 1'b1;
    send_word(32'h7abc_de12, 5'd10);
    send_word(WordRoll, 5'd11);
    send_word(32'hffff_ffff, 5'd12);
    send_word(32'hf123_4567, 5'd16);
    wait_drained();
  endtask

  task automatic test_random_spills();
    int unsigned start;
    int unsigned body;
    logic [1:0]  mode;
    start = decoded_words;
    while (decoded_words - start < SpillItems) begin
      mode = 2'($urandom_range(0, 3));
      push_idle_en = mode[0];
      pop_idle_en = mode[1];
      // a little junk before the header
      repeat ($urandom_range(0, 2)) begin
        logic [31:0] junk;
        junk = $urandom;
        if ((junk & NibMask) == NibHeader) junk[31] = 1'b1;
        send_word(junk, draw_fifo());
      end
      send_word(NibHeader | ($urandom & ~NibMask), draw_fifo());
      send_word(draw_time_low(), draw_fifo());
      body = $urandom_range(0, 14);
      repeat (body) begin
        if ($urandom_range(0, 5) == 0) send_word(WordRoll, draw_fifo());
        else send_word(draw_hit_word(), draw_fifo());
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          send_word(NibTrailer | ($urandom & ~NibMask), draw_fifo());
          send_word(draw_time_low(), draw_fifo());
        end
        5, 6, 7: send_word(WordKilled, draw_fifo());
        // leave the spill open: the next header lands inside it
        default: ;
      endcase
    end
    wait_drained();
  endtask

  task automatic test_random_noise();
    int unsigned start;
    logic [31:0] w;
    push_idle_en = 1'b1;
    pop_idle_en = 1'b1;
    start = decoded_words;
    while (decoded_words - start < NoiseItems) begin
      case ($urandom_range(0, 9))
        0, 1:    w = NibHeader | ($urandom & ~NibMask);
        2:       w = NibTrailer | ($urandom & ~NibMask);
        3:       w = WordKilled;
        4:       w = WordRoll;
        5, 6, 7: w = draw_hit_word();
        default: w = $urandom;
      endcase
      send_word(w, draw_fifo());
      if ($urandom_range(0, 31) == 0) begin
        push_idle_en = ~push_idle_en;
        pop_idle_en = 1'($urandom_range(0, 1));
      end
    end
    wait_drained();
  endtask

  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = pop_idle_en ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_records
    rec_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_records.size() == 0) begin
        report_mismatch("unexpected record type", 32'(record_type_o), '0);
      end else begin
        want = pending_records.pop_front();
        if (record_type_o !== want.record_type)
          report_mismatch("record_type", 32'(record_type_o), 32'(want.record_type));
        if (source_fifo_o !== want.source_fifo)
          report_mismatch("source_fifo", 32'(source_fifo_o), 32'(want.source_fifo));
        if (spill_counter_o !== want.spill_counter)
          report_mismatch("spill_counter", 32'(spill_counter_o), 32'(want.spill_counter));
        if (column_o !== want.column)
          report_mismatch("column", 32'(column_o), 32'(want.column));
        if (pixel_o !== want.pixel)
          report_mismatch("pixel", 32'(pixel_o), 32'(want.pixel));
        if (tdc_o !== want.tdc)
          report_mismatch("tdc", 32'(tdc_o), 32'(want.tdc));
        if (rollover_o !== want.rollover)
          report_mismatch("rollover", 32'(rollover_o), 32'(want.rollover));
        if (coarse_o !== want.coarse)
          report_mismatch("coarse", 32'(coarse_o), 32'(want.coarse));
        if (fine_o !== want.fine)
          report_mismatch("fine", 32'(fine_o), 32'(want.fine));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
      if (quiet >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_cases();
    test_random_spills();
    test_random_noise();
    if (err_count == 0 && pending_records.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
